// ----- hdl/assert_macros.svh -----
// Assertion macros shared by the RTL of the TS PSI parser.
// Uses the clk and rst_n names of the module that includes it.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked property, skipped while reset is held.
`define TP_ASSERT(lbl, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("assertion failed");
// Checked property, also checked during reset.
`define TP_ASSERT_ALWAYS(lbl, prop) \
  lbl: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define TP_ASSERT(lbl, prop)
`define TP_ASSERT_ALWAYS(lbl, prop)
`endif
`endif

// ----- hdl/ts_pp_pkg.sv -----
// Package for the TS PAT/PMT parser: types, result codes, defaults.
// No dependencies.
`default_nettype none
package ts_pp_pkg;

  localparam int MAX_PROGRAMS_DEF = 32;

  // result kinds
  localparam logic [2:0] K_PAT_PROG = 3'd0;
  localparam logic [2:0] K_PAT_NET  = 3'd1;
  localparam logic [2:0] K_PMT_HDR  = 3'd2;
  localparam logic [2:0] K_PMT_ES   = 3'd3;
  localparam logic [2:0] K_STATUS   = 3'd4;

  // error codes
  localparam logic [2:0] E_NONE     = 3'd0;
  localparam logic [2:0] E_ZERO_BIT = 3'd1;
  localparam logic [2:0] E_PAST_LAST = 3'd2;
  localparam logic [2:0] E_FULL     = 3'd3;
  localparam logic [2:0] E_SHORT    = 3'd4;

  typedef enum logic [2:0] {
    M_IDLE, M_PAT, M_PMT_HDR, M_SKIP, M_LOOP, M_DONE, M_IGNORE
  } mode_t;

  typedef enum logic [1:0] {T_IDLE, T_WAIT, T_EXEC, T_OUT} top_state_t;

  typedef enum logic [1:0] {SR_IDLE, SR_RD, SR_CMP} srch_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] program_id;
    logic [12:0] entry_pid;
    logic [7:0]  stream_kind;
    logic [11:0] info_length;
    logic        pat_complete;
    logic        all_done;
    logic [2:0]  error_code;
    logic        last_of_run;
  } res_t;

endpackage
`default_nettype wire

// ----- hdl/ts_pp_table.sv -----
// Key table with a sequential search: one read and one compare per step.
// Depends on ts_pp_pkg.
`default_nettype none
module ts_pp_table #(
  parameter int Depth = 32,
  parameter int Width = 16,
  parameter int IdxW  = 5,
  parameter int CntW  = 6
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             start,
  input  wire logic [Width-1:0] key,
  input  wire logic [CntW-1:0]  count,
  input  wire logic             wr_en,
  input  wire logic [Width-1:0] wr_data,
  output logic                  done,
  output logic                  hit
);
  import ts_pp_pkg::*;

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rd_data_r;
  logic [IdxW-1:0]  idx_r, idx_nxt;
  logic [Width-1:0] key_r, key_nxt;
  srch_state_t      st_r, st_nxt;
  logic             done_r, done_nxt, hit_r, hit_nxt;
  logic             last;

  // storage: write at the fill count, read at the search index
  always_ff @(posedge clk) begin
    if (wr_en) mem[count[IdxW-1:0]] <= wr_data;
    rd_data_r <= mem[idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= SR_IDLE;
      done_r <= 1'b0;
      hit_r  <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
      hit_r  <= hit_nxt;
    end
    idx_r <= idx_nxt;
    key_r <= key_nxt;
  end

  assign last = (CntW'(idx_r) + CntW'(1)) == count;

  // search sequencer
  always_comb begin
    st_nxt   = st_r;
    idx_nxt  = idx_r;
    key_nxt  = key_r;
    done_nxt = 1'b0;
    hit_nxt  = hit_r;
    unique case (st_r)
      SR_IDLE: begin
        if (start) begin
          key_nxt = key;
          idx_nxt = '0;
          hit_nxt = 1'b0;
          if (count == '0) done_nxt = 1'b1;
          else st_nxt = SR_RD;
        end
      end
      SR_RD: st_nxt = SR_CMP;
      SR_CMP: begin
        if (rd_data_r == key_r) begin
          hit_nxt  = 1'b1;
          done_nxt = 1'b1;
          st_nxt   = SR_IDLE;
        end else if (last) begin
          done_nxt = 1'b1;
          st_nxt   = SR_IDLE;
        end else begin
          idx_nxt = idx_r + IdxW'(1);
          st_nxt  = SR_RD;
        end
      end
      default: st_nxt = SR_IDLE;
    endcase
  end

  assign done = done_r;
  assign hit  = hit_r;
endmodule
`default_nettype wire

// ----- hdl/ts_psi_pat_pmt_parser.sv -----
// TS PAT/PMT section parser.
// Takes one payload byte per transaction on the in_ channel (byte, PID,
// payload_end). Each accepted byte is worked on alone: the byte is latched,
// the map PID table (first byte of a payload) or the stored program table
// (PMT byte 4) is searched one entry at a time, then the byte is
// executed and its results are sent.
// Per byte: at most two results (an entry and a status), each taken
// while out_stall is low.
// in_stall stays high from acceptance until the last result of that byte
// is taken; a stalled result holds. Result order: entry, then status.
// Reset (rst_n low, synchronous) clears counts, PAT seen flags and parse
// state; the tables hold nothing valid until written, only entries below
// their counts are searched.
// Depends on ts_pp_pkg, ts_pp_table and assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ts_psi_pat_pmt_parser #(
  parameter int MAX_PROGRAMS = ts_pp_pkg::MAX_PROGRAMS_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  in_data_byte,
  input  wire logic [12:0] in_packet_pid,
  input  wire logic        in_payload_end,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [2:0]       out_kind,
  output logic [15:0]      out_program_id,
  output logic [12:0]      out_entry_pid,
  output logic [7:0]       out_stream_kind,
  output logic [11:0]      out_info_length,
  output logic             out_pat_complete,
  output logic             out_all_done,
  output logic [2:0]       out_error_code,
  output logic             out_last_of_run
);
  import ts_pp_pkg::*;

  localparam int IdxW = (MAX_PROGRAMS > 1) ? $clog2(MAX_PROGRAMS) : 1;
  localparam int CntW = $clog2(MAX_PROGRAMS + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_PROGRAMS);

  top_state_t  ts_r, ts_nxt;
  logic [7:0]  b_r;
  logic [12:0] pid_r;
  logic        pend_r, hit_r;
  logic [11:0] bpos_r, bpos_nxt;
  logic [11:0] ss_r, ss_nxt;
  logic [39:0] acc_r, acc_nxt;
  mode_t       mode_r, mode_nxt;
  logic        drop_r, drop_nxt;
  logic [2:0]  perr_r, perr_nxt;
  logic [15:0] curp_r, curp_nxt;
  logic [11:0] skip_r, skip_nxt;
  logic [2:0]  eidx_r, eidx_nxt;
  logic        patf_r, patf_nxt;
  logic [CntW-1:0] mapc_r, mapc_nxt, pmtc_r, pmtc_nxt;
  logic [255:0] seen_r;
  logic        seen_we;
  res_t        res_r [2];
  res_t        ent, stat;
  logic        ent_v;
  logic [1:0]  nres_r;
  logic        sel_r;
  logic        map_we, pmt_we;
  logic        map_start, pmt_start, map_done, pmt_done, map_hit, pmt_hit;
  logic        in_acc, out_acc;
  logic [39:0] prev;
  logic [11:0] lend;
  logic [13:0] pat_need;
  logic        shortp;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // map PID table and PMT program table, each with its search unit
  ts_pp_table #(.Depth(MAX_PROGRAMS), .Width(16), .IdxW(IdxW), .CntW(CntW)) u_map (
    .clk, .rst_n, .start(map_start), .key({3'b000, in_packet_pid}), .count(mapc_r),
    .wr_en(map_we), .wr_data({3'b000, ent.entry_pid}), .done(map_done), .hit(map_hit)
  );
  ts_pp_table #(.Depth(MAX_PROGRAMS), .Width(16), .IdxW(IdxW), .CntW(CntW)) u_pmt (
    .clk, .rst_n, .start(pmt_start), .key({acc_r[7:0], in_data_byte}), .count(pmtc_r),
    .wr_en(pmt_we), .wr_data(curp_r), .done(pmt_done), .hit(pmt_hit)
  );

  // byte sequencer
  always_comb begin
    ts_nxt    = ts_r;
    map_start = 1'b0;
    pmt_start = 1'b0;
    unique case (ts_r)
      T_IDLE: begin
        if (in_acc) begin
          if (bpos_r == '0 && in_packet_pid != '0) begin
            map_start = 1'b1;
            ts_nxt    = T_WAIT;
          end else if (bpos_r == 12'd4 && mode_r == M_PMT_HDR) begin
            pmt_start = 1'b1;
            ts_nxt    = T_WAIT;
          end else begin
            ts_nxt = T_EXEC;
          end
        end
      end
      T_WAIT:  if (map_done || pmt_done) ts_nxt = T_EXEC;
      T_EXEC:  ts_nxt = (ent_v || pend_r) ? T_OUT : T_IDLE;
      T_OUT:   if (out_acc && (sel_r || nres_r == 2'd1)) ts_nxt = T_IDLE;
      default: ts_nxt = T_IDLE;
    endcase
  end

  assign lend     = (ss_nxt >= 12'd1) ? ss_nxt - 12'd1 : 12'd0;
  assign pat_need = (ss_nxt >= 12'd9) ? 14'd8 + {((ss_nxt - 12'd9) >> 2), 2'b00} : 14'd8;

  // byte execution
  always_comb begin
    bpos_nxt = bpos_r;
    ss_nxt   = ss_r;
    acc_nxt  = acc_r;
    mode_nxt = mode_r;
    drop_nxt = drop_r;
    perr_nxt = perr_r;
    curp_nxt = curp_r;
    skip_nxt = skip_r;
    eidx_nxt = eidx_r;
    patf_nxt = patf_r;
    mapc_nxt = mapc_r;
    pmtc_nxt = pmtc_r;
    map_we   = 1'b0;
    pmt_we   = 1'b0;
    seen_we  = 1'b0;
    ent_v    = 1'b0;
    ent      = '0;
    stat     = '0;
    shortp   = 1'b0;
    prev     = acc_r;
    if (ts_r == T_EXEC) begin
      if (bpos_r == '0) begin
        drop_nxt = 1'b0;
        perr_nxt = E_NONE;
        ss_nxt   = '0;
        acc_nxt  = '0;
        eidx_nxt = '0;
        skip_nxt = '0;
        mode_nxt = (pid_r == '0) ? M_PAT : (hit_r ? M_PMT_HDR : M_IGNORE);
      end
      prev = acc_nxt;
      if (mode_nxt == M_PAT) begin
        acc_nxt = {prev[31:0], b_r};
        if (bpos_r == 12'd0) begin
          patf_nxt = 1'b0;
        end else if (bpos_r == 12'd1) begin
          if (b_r[6]) begin
            if (perr_nxt == E_NONE) perr_nxt = E_ZERO_BIT;
            mode_nxt = M_IGNORE;
          end
        end else if (bpos_r == 12'd2) begin
          ss_nxt = {prev[3:0], b_r};
        end else if (bpos_r == 12'd6) begin
          drop_nxt = seen_r[b_r];
        end else if (bpos_r == 12'd7) begin
          if (prev[7:0] > b_r) begin
            if (perr_nxt == E_NONE) perr_nxt = E_PAST_LAST;
            mode_nxt = M_IGNORE;
          end else begin
            patf_nxt = (prev[7:0] == b_r);
            seen_we  = !drop_nxt;
          end
        end else if (bpos_r >= 12'd8 && bpos_r[1:0] == 2'b11) begin
          if ({1'b0, bpos_r} + 13'd2 <= {1'b0, ss_nxt} && !drop_nxt) begin
            ent_v         = 1'b1;
            ent.entry_pid = acc_nxt[12:0];
            if (acc_nxt[31:16] == 16'd0) begin
              ent.kind = K_PAT_NET;
            end else begin
              ent.kind       = K_PAT_PROG;
              ent.program_id = acc_nxt[31:16];
              if (mapc_r < CntMax) begin
                map_we   = 1'b1;
                mapc_nxt = mapc_r + CntW'(1);
              end else if (perr_nxt == E_NONE) begin
                perr_nxt = E_FULL;
              end
            end
          end
        end
      end else if (mode_nxt == M_SKIP) begin
        if (skip_r != '0) skip_nxt = skip_r - 12'd1;
        if (skip_nxt == '0) mode_nxt = M_LOOP;
      end else if (mode_nxt == M_LOOP && eidx_r == '0 && bpos_r >= lend) begin
        mode_nxt = M_DONE;
      end else if (mode_nxt == M_PMT_HDR) begin
        acc_nxt = {prev[31:0], b_r};
        if (bpos_r == 12'd1) begin
          if (b_r[6]) begin
            if (perr_nxt == E_NONE) perr_nxt = E_ZERO_BIT;
            mode_nxt = M_IGNORE;
          end
        end else if (bpos_r == 12'd2) begin
          ss_nxt = {prev[3:0], b_r};
        end else if (bpos_r == 12'd4) begin
          curp_nxt = acc_nxt[15:0];
          drop_nxt = hit_r;
        end else if (bpos_r == 12'd11) begin
          if (!drop_nxt) begin
            ent_v           = 1'b1;
            ent.kind        = K_PMT_HDR;
            ent.program_id  = curp_r;
            ent.entry_pid   = acc_nxt[28:16];
            ent.info_length = acc_nxt[11:0];
            if (pmtc_r < CntMax) begin
              pmt_we   = 1'b1;
              pmtc_nxt = pmtc_r + CntW'(1);
            end else if (perr_nxt == E_NONE) begin
              perr_nxt = E_FULL;
            end
          end
          eidx_nxt = '0;
          skip_nxt = acc_nxt[11:0];
          mode_nxt = (acc_nxt[11:0] != '0) ? M_SKIP : M_LOOP;
        end
      end else if (mode_nxt == M_LOOP) begin
        acc_nxt  = {prev[31:0], b_r};
        eidx_nxt = eidx_r + 3'd1;
        if (eidx_nxt >= 3'd5) begin
          eidx_nxt = '0;
          if (acc_nxt[11:0] != '0) begin
            skip_nxt = acc_nxt[11:0];
            mode_nxt = M_SKIP;
          end
          if (!drop_nxt) begin
            ent_v           = 1'b1;
            ent.kind        = K_PMT_ES;
            ent.stream_kind = acc_nxt[39:32];
            ent.entry_pid   = acc_nxt[28:16];
            ent.info_length = acc_nxt[11:0];
          end
        end
      end
      bpos_nxt = (bpos_r < 12'd4095) ? bpos_r + 12'd1 : bpos_r;
      // payload status
      if (pend_r) begin
        if (mode_nxt == M_PAT) begin
          shortp = (bpos_nxt < 12'd8) || ({2'b00, bpos_nxt} < pat_need);
        end else if (mode_nxt == M_PMT_HDR || mode_nxt == M_SKIP) begin
          shortp = 1'b1;
        end else if (mode_nxt == M_LOOP) begin
          shortp = (eidx_nxt != '0) || (bpos_nxt < lend);
        end
        if (shortp && perr_nxt == E_NONE) perr_nxt = E_SHORT;
        stat.kind         = K_STATUS;
        stat.pat_complete = patf_nxt;
        stat.all_done     = patf_nxt && (pmtc_nxt == mapc_nxt);
        stat.error_code   = perr_nxt;
        stat.last_of_run  = 1'b1;
        bpos_nxt = '0;
        mode_nxt = M_IDLE;
        perr_nxt = E_NONE;
        drop_nxt = 1'b0;
      end
    end
  end

  // control and parse state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ts_r   <= T_IDLE;
      bpos_r <= '0;
      ss_r   <= '0;
      acc_r  <= '0;
      mode_r <= M_IDLE;
      drop_r <= 1'b0;
      perr_r <= E_NONE;
      curp_r <= '0;
      skip_r <= '0;
      eidx_r <= '0;
      patf_r <= 1'b0;
      mapc_r <= '0;
      pmtc_r <= '0;
      seen_r <= '0;
      sel_r  <= 1'b0;
      nres_r <= '0;
    end else begin
      ts_r   <= ts_nxt;
      bpos_r <= bpos_nxt;
      ss_r   <= ss_nxt;
      acc_r  <= acc_nxt;
      mode_r <= mode_nxt;
      drop_r <= drop_nxt;
      perr_r <= perr_nxt;
      curp_r <= curp_nxt;
      skip_r <= skip_nxt;
      eidx_r <= eidx_nxt;
      patf_r <= patf_nxt;
      mapc_r <= mapc_nxt;
      pmtc_r <= pmtc_nxt;
      if (seen_we) seen_r[acc_r[7:0]] <= 1'b1;
      if (ts_r == T_EXEC) begin
        nres_r <= {1'b0, ent_v} + {1'b0, pend_r};
        sel_r  <= 1'b0;
      end else if (out_acc) begin
        sel_r <= 1'b1;
      end
    end
  end

  // latched byte, search result and result slots
  always_ff @(posedge clk) begin
    if (in_acc) begin
      b_r    <= in_data_byte;
      pid_r  <= in_packet_pid;
      pend_r <= in_payload_end;
    end
    if (map_done) hit_r <= map_hit;
    else if (pmt_done) hit_r <= pmt_hit;
    if (ts_r == T_EXEC) begin
      res_r[0] <= ent_v ? ent : stat;
      res_r[1] <= stat;
    end
  end

  assign in_stall         = (ts_r != T_IDLE);
  assign out_valid        = (ts_r == T_OUT);
  assign out_kind         = res_r[sel_r].kind;
  assign out_program_id   = res_r[sel_r].program_id;
  assign out_entry_pid    = res_r[sel_r].entry_pid;
  assign out_stream_kind  = res_r[sel_r].stream_kind;
  assign out_info_length  = res_r[sel_r].info_length;
  assign out_pat_complete = res_r[sel_r].pat_complete;
  assign out_all_done     = res_r[sel_r].all_done;
  assign out_error_code   = res_r[sel_r].error_code;
  assign out_last_of_run  = res_r[sel_r].last_of_run;

  `TP_ASSERT(a_no_out_when_ready, !in_stall |-> !out_valid)
  `TP_ASSERT(a_stall_after_accept, in_valid && !in_stall |=> in_stall)
  `TP_ASSERT(a_status_closes, out_valid && out_kind == K_STATUS |-> out_last_of_run)
  `TP_ASSERT(a_count_bound, mapc_r <= CntMax && pmtc_r <= CntMax)
endmodule
`default_nettype wire
